// ===== rtl/core/slab_pkg.sv =====
package slab_pkg;

   localparam int PAGE_BYTES   = 4096;
   localparam int PAGE_SHIFT   = 12;
   localparam int NUM_FRAMES   = 16;
   localparam int FRAME_BITS   = 4;
   localparam int FREE_DEPTH   = 8192;
   localparam int ADDR_BITS    = 13;
   localparam int TOP_BITS     = 14;
   localparam int HEADER_BYTES = 32;
   localparam int GEO_BITS     = 13;
   localparam int SLOT_BITS    = 9;
   localparam int CNT_BITS     = 14;
   localparam int OWN_BITS     = 5;
   localparam int DIV_CNT_BITS = 4;

   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_FREE    = 2'd1,
      REQ_DESTROY = 2'd2,
      REQ_NONE    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INACTIVE = 3'd1,
      ST_NOFRAME  = 3'd2,
      ST_REJECT   = 3'd3,
      ST_REFUSED  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_ENABLE       = 2'd0,
      CSR_OBJECT_BYTES = 2'd1,
      CSR_ALIGN_BYTES  = 2'd2,
      CSR_POOL_BASE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic       latch_req;
      logic       geo_start;
      logic       div_step;
      logic       geo_finish;
      logic       set_status;
      status_type status;
      logic       fill_init;
      logic       fill_step;
      logic       pop_read;
      logic       pop_finish;
      logic       push;
      logic       recl_init;
      logic       recl_step;
      logic       recl_finish;
      logic       drop_all;
   } slab_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         active;
      logic         top_empty;
      logic         can_fill;
      logic         free_ok;
      logic         live_zero;
      logic         recl_needed;
      logic         fill_last;
      logic         recl_done;
   } slab_stat_type;

endpackage

// ===== rtl/core/slab_ctrl.sv =====
module slab_ctrl
   import slab_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_strobe,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic          csr_enable_bit,
   input  slab_stat_type stat,
   output slab_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_GDIV, S_GEND, S_DECIDE, S_FILL, S_POP, S_POPWB, S_RCHK, S_RECL, S_RESP
   } state_type;

   state_type               state_ff, state_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff, div_cnt_in;
   logic                    csr_fire;

   assign busy       = (state_ff != S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE) && !start;
   assign rsp_strobe = (state_ff == S_RESP);
   assign csr_fire   = csr_valid && csr_ready;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.status = ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (csr_fire && csr_index == CSR_ENABLE && csr_enable_bit) begin
               cmd.geo_start = 1'b1;
               div_cnt_in    = '0;
               state_in      = S_GDIV;
            end else if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_GDIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_BITS'(GEO_BITS - 1)) state_in = S_GEND;
         end
         S_GEND: begin
            cmd.geo_finish = 1'b1;
            state_in       = S_IDLE;
         end
         S_DECIDE: begin
            cmd.set_status = 1'b1;
            state_in       = S_RESP;
            if (stat.kind == REQ_NONE) begin
               cmd.status = ST_OK;
            end else if (!stat.active) begin
               cmd.status = ST_INACTIVE;
            end else begin
               case (stat.kind)
                  REQ_ALLOC: begin
                     if (!stat.top_empty) begin
                        cmd.set_status = 1'b0;
                        state_in       = S_POP;
                     end else if (stat.can_fill) begin
                        cmd.set_status = 1'b0;
                        cmd.fill_init  = 1'b1;
                        state_in       = S_FILL;
                     end else begin
                        cmd.status = ST_NOFRAME;
                     end
                  end
                  REQ_FREE: begin
                     if (stat.free_ok) begin
                        cmd.push   = 1'b1;
                        cmd.status = ST_OK;
                        state_in   = S_RCHK;
                     end else begin
                        cmd.status = ST_REJECT;
                     end
                  end
                  REQ_DESTROY: begin
                     if (stat.live_zero) begin
                        cmd.drop_all = 1'b1;
                        cmd.status   = ST_OK;
                     end else begin
                        cmd.status = ST_REFUSED;
                     end
                  end
                  default: cmd.status = ST_OK;
               endcase
            end
         end
         S_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) state_in = S_POP;
         end
         S_POP: begin
            cmd.pop_read = 1'b1;
            state_in     = S_POPWB;
         end
         S_POPWB: begin
            cmd.pop_finish = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = ST_OK;
            state_in       = S_RESP;
         end
         S_RCHK: begin
            if (stat.recl_needed) begin
               cmd.recl_init = 1'b1;
               state_in      = S_RECL;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RECL: begin
            if (stat.recl_done) begin
               cmd.recl_finish = 1'b1;
               state_in        = S_RESP;
            end else begin
               cmd.recl_step = 1'b1;
            end
         end
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !busy) else $error("strobe not followed by idle");
   a_no_start_when_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.latch_req) else $error("request latched while busy");
   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GDIV) |-> (div_cnt_ff < DIV_CNT_BITS'(GEO_BITS)))
      else $error("divider overran");

endmodule

// ===== rtl/core/slab_dp.sv =====
module slab_dp
   import slab_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  slab_cmd_type        cmd,
   output slab_stat_type       stat,
   input  logic [1:0]          req_type,
   input  logic [31:0]         req_obj_address,
   input  logic                csr_fire,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_result_address,
   output logic [CNT_BITS-1:0] rsp_allocated_count,
   output logic [OWN_BITS-1:0] rsp_frame_count,
   output logic [CNT_BITS-1:0] rsp_object_total,
   output logic [CNT_BITS-1:0] rsp_peak_allocated
);

   localparam int HI_BITS = 32 - PAGE_SHIFT - FRAME_BITS;

   // configuration
   logic [GEO_BITS-1:0] cfg_obj_ff, cfg_obj_in, cfg_align_ff, cfg_align_in;
   logic [31:0]         cfg_base_ff, cfg_base_in;

   // latched geometry and divider
   logic [GEO_BITS-1:0]  geo_size_ff, geo_size_in, geo_first_ff, geo_first_in;
   logic [31:0]          geo_base_ff, geo_base_in;
   logic                 geo_ok_ff, geo_ok_in;
   logic [SLOT_BITS-1:0] per_page_ff, per_page_in;
   logic [GEO_BITS-1:0]  div_rem_ff, div_rem_in, div_q_ff, div_q_in;

   // cache state
   logic                 active_ff, active_in;
   logic [TOP_BITS-1:0]  top_ff, top_in;
   logic [NUM_FRAMES-1:0] owned_ff, owned_in;
   logic [SLOT_BITS-1:0] slots_ff [NUM_FRAMES];
   logic [SLOT_BITS-1:0] slots_in [NUM_FRAMES];
   logic [CNT_BITS-1:0]  live_ff, live_in, peak_ff, peak_in, slot_total_ff, slot_total_in;
   logic [OWN_BITS-1:0]  own_cnt_ff, own_cnt_in;

   // request, response
   req_kind_type         kind_ff, kind_in;
   logic [31:0]          addr_ff, addr_in, result_ff, result_in;
   status_type           status_ff, status_in;

   // fill and reclaim walkers
   logic [31:0]          fill_ptr_ff, fill_ptr_in;
   logic [SLOT_BITS-1:0] fill_cnt_ff, fill_cnt_in;
   logic [TOP_BITS-1:0]  ri_ff, ri_in, rj_ff, rj_in;
   logic                 pend_ff, pend_in;

   // stack memory
   logic [31:0]          mem [FREE_DEPTH];
   logic [31:0]          rd_data_ff;
   logic                 mem_we, mem_re;
   logic [ADDR_BITS-1:0] mem_wa, mem_ra;
   logic [31:0]          mem_wd;

   // geometry from configuration
   logic [GEO_BITS-1:0] al, amask;
   logic [GEO_BITS:0]   size14, first14, sz_sum, first_sum;
   logic                geo_ok;

   always_comb begin
      al        = (cfg_align_ff < GEO_BITS'(8)) ? GEO_BITS'(8) : cfg_align_ff;
      amask     = al - 1'b1;
      sz_sum    = {1'b0, cfg_obj_ff} + {1'b0, amask};
      size14    = sz_sum & ~{1'b0, amask};
      first_sum = (GEO_BITS+1)'(HEADER_BYTES) + {1'b0, amask};
      first14   = first_sum & ~{1'b0, amask};
      geo_ok    = (cfg_obj_ff != '0) && (cfg_obj_ff <= GEO_BITS'(PAGE_BYTES))
                  && ((al & amask) == '0) && (al <= GEO_BITS'(PAGE_BYTES))
                  && (first14 < (GEO_BITS+1)'(PAGE_BYTES))
                  && (size14 <= (GEO_BITS+1)'(PAGE_BYTES) - first14);
   end

   // frame of request address and of the word read back
   logic [31:0]           roff, doff;
   logic                  r_hi_zero, d_hi_zero;
   logic [FRAME_BITS-1:0] rf, df;

   assign roff      = addr_ff - geo_base_ff;
   assign doff      = rd_data_ff - geo_base_ff;
   assign r_hi_zero = (roff[31 -: HI_BITS] == '0);
   assign d_hi_zero = (doff[31 -: HI_BITS] == '0);
   assign rf        = roff[PAGE_SHIFT +: FRAME_BITS];
   assign df        = doff[PAGE_SHIFT +: FRAME_BITS];

   // lowest unowned frame
   logic [FRAME_BITS-1:0] free_f;
   logic                  free_found;

   always_comb begin
      free_f     = '0;
      free_found = 1'b0;
      for (int k = NUM_FRAMES - 1; k >= 0; k--) begin
         if (!owned_ff[k]) begin
            free_f     = FRAME_BITS'(k);
            free_found = 1'b1;
         end
      end
   end

   logic                div_ge;
   logic [GEO_BITS:0]   rem_sh;
   logic                keep, ri_more;

   assign rem_sh  = {div_rem_ff, div_q_ff[GEO_BITS-1]};
   assign div_ge  = (rem_sh >= {1'b0, geo_size_ff});
   assign keep    = !(d_hi_zero && df == rf);
   assign ri_more = (ri_ff < top_ff);

   always_comb begin
      stat.kind        = kind_ff;
      stat.active      = active_ff;
      stat.top_empty   = (top_ff == '0);
      stat.can_fill    = free_found && (per_page_ff != '0)
                         && (TOP_BITS'(per_page_ff) <= TOP_BITS'(FREE_DEPTH) - top_ff);
      stat.free_ok     = (addr_ff != '0) && r_hi_zero && owned_ff[rf]
                         && (slots_ff[rf] < per_page_ff) && (top_ff < TOP_BITS'(FREE_DEPTH));
      stat.live_zero   = (live_ff == '0);
      stat.recl_needed = (slots_ff[rf] == per_page_ff) && (own_cnt_ff > OWN_BITS'(1));
      stat.fill_last   = (fill_cnt_ff == per_page_ff - 1'b1);
      stat.recl_done   = !ri_more && !pend_ff;
   end

   always_comb begin
      cfg_obj_in    = cfg_obj_ff;
      cfg_align_in  = cfg_align_ff;
      cfg_base_in   = cfg_base_ff;
      geo_size_in   = geo_size_ff;
      geo_first_in  = geo_first_ff;
      geo_base_in   = geo_base_ff;
      geo_ok_in     = geo_ok_ff;
      per_page_in   = per_page_ff;
      div_rem_in    = div_rem_ff;
      div_q_in      = div_q_ff;
      active_in     = active_ff;
      top_in        = top_ff;
      owned_in      = owned_ff;
      slots_in      = slots_ff;
      live_in       = live_ff;
      peak_in       = peak_ff;
      slot_total_in = slot_total_ff;
      own_cnt_in    = own_cnt_ff;
      kind_in       = kind_ff;
      addr_in       = addr_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      fill_ptr_in   = fill_ptr_ff;
      fill_cnt_in   = fill_cnt_ff;
      ri_in         = ri_ff;
      rj_in         = rj_ff;
      pend_in       = pend_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = '0;
      mem_re        = 1'b0;
      mem_ra        = '0;

      if (csr_fire) begin
         case (csr_index)
            CSR_ENABLE:       if (!csr_wdata[0]) active_in = 1'b0;
            CSR_OBJECT_BYTES: cfg_obj_in = csr_wdata[GEO_BITS-1:0];
            CSR_ALIGN_BYTES:  cfg_align_in = csr_wdata[GEO_BITS-1:0];
            CSR_POOL_BASE:    cfg_base_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.geo_start) begin
         geo_size_in   = size14[GEO_BITS-1:0];
         geo_first_in  = first14[GEO_BITS-1:0];
         geo_ok_in     = geo_ok;
         geo_base_in   = cfg_base_ff;
         div_rem_in    = '0;
         div_q_in      = GEO_BITS'(PAGE_BYTES) - first14[GEO_BITS-1:0];
         active_in     = 1'b0;
         top_in        = '0;
         owned_in      = '0;
         for (int k = 0; k < NUM_FRAMES; k++) slots_in[k] = '0;
         live_in       = '0;
         peak_in       = '0;
         slot_total_in = '0;
         own_cnt_in    = '0;
      end

      // restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         div_rem_in = div_ge ? GEO_BITS'(rem_sh - {1'b0, geo_size_ff})
                             : rem_sh[GEO_BITS-1:0];
         div_q_in   = {div_q_ff[GEO_BITS-2:0], div_ge};
      end

      if (cmd.geo_finish) begin
         per_page_in = geo_ok_ff ? div_q_ff[SLOT_BITS-1:0] : '0;
         active_in   = geo_ok_ff;
      end

      if (cmd.latch_req) begin
         kind_in   = req_kind_type'(req_type);
         addr_in   = req_obj_address;
         result_in = '0;
      end

      if (cmd.set_status) status_in = cmd.status;

      if (cmd.fill_init) begin
         owned_in[free_f] = 1'b1;
         slots_in[free_f] = per_page_ff;
         own_cnt_in       = own_cnt_ff + 1'b1;
         slot_total_in    = slot_total_ff + CNT_BITS'(per_page_ff);
         fill_ptr_in      = geo_base_ff + (32'(free_f) << PAGE_SHIFT) + 32'(geo_first_ff);
         fill_cnt_in      = '0;
      end

      if (cmd.fill_step) begin
         mem_we      = 1'b1;
         mem_wa      = top_ff[ADDR_BITS-1:0];
         mem_wd      = fill_ptr_ff;
         top_in      = top_ff + 1'b1;
         fill_ptr_in = fill_ptr_ff + 32'(geo_size_ff);
         fill_cnt_in = fill_cnt_ff + 1'b1;
      end

      if (cmd.pop_read) begin
         mem_re = 1'b1;
         mem_ra = ADDR_BITS'(top_ff - 1'b1);
         top_in = top_ff - 1'b1;
      end

      if (cmd.pop_finish) begin
         result_in = rd_data_ff;
         if (d_hi_zero && slots_ff[df] != '0) slots_in[df] = slots_ff[df] - 1'b1;
         live_in = live_ff + 1'b1;
         if (live_in > peak_ff) peak_in = live_in;
      end

      if (cmd.push) begin
         mem_we       = 1'b1;
         mem_wa       = top_ff[ADDR_BITS-1:0];
         mem_wd       = addr_ff;
         top_in       = top_ff + 1'b1;
         slots_in[rf] = slots_ff[rf] + 1'b1;
         if (live_ff != '0) live_in = live_ff - 1'b1;
      end

      if (cmd.recl_init) begin
         ri_in   = '0;
         rj_in   = '0;
         pend_in = 1'b0;
      end

      // compaction: read at ri, write kept words back at rj in the following cycle
      if (cmd.recl_step) begin
         pend_in = ri_more;
         if (ri_more) begin
            mem_re = 1'b1;
            mem_ra = ri_ff[ADDR_BITS-1:0];
            ri_in  = ri_ff + 1'b1;
         end
         if (pend_ff && keep) begin
            mem_we = 1'b1;
            mem_wa = rj_ff[ADDR_BITS-1:0];
            mem_wd = rd_data_ff;
            rj_in  = rj_ff + 1'b1;
         end
      end

      if (cmd.recl_finish) begin
         top_in        = rj_ff;
         owned_in[rf]  = 1'b0;
         slots_in[rf]  = '0;
         slot_total_in = (slot_total_ff >= CNT_BITS'(per_page_ff))
                         ? slot_total_ff - CNT_BITS'(per_page_ff) : '0;
         own_cnt_in    = own_cnt_ff - 1'b1;
      end

      if (cmd.drop_all) begin
         top_in        = '0;
         owned_in      = '0;
         for (int k = 0; k < NUM_FRAMES; k++) slots_in[k] = '0;
         slot_total_in = '0;
         own_cnt_in    = '0;
         active_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      geo_size_in_reg: begin
         geo_size_ff  <= geo_size_in;
         geo_first_ff <= geo_first_in;
         geo_ok_ff    <= geo_ok_in;
         div_rem_ff   <= div_rem_in;
         div_q_ff     <= div_q_in;
         addr_ff      <= addr_in;
         fill_ptr_ff  <= fill_ptr_in;
         fill_cnt_ff  <= fill_cnt_in;
         ri_ff        <= ri_in;
         rj_ff        <= rj_in;
      end
      if (reset) begin
         cfg_obj_ff    <= GEO_BITS'(16);
         cfg_align_ff  <= GEO_BITS'(16);
         cfg_base_ff   <= 32'd1048576;
         geo_base_ff   <= '0;
         per_page_ff   <= '0;
         active_ff     <= 1'b0;
         top_ff        <= '0;
         owned_ff      <= '0;
         for (int k = 0; k < NUM_FRAMES; k++) slots_ff[k] <= '0;
         live_ff       <= '0;
         peak_ff       <= '0;
         slot_total_ff <= '0;
         own_cnt_ff    <= '0;
         kind_ff       <= REQ_NONE;
         result_ff     <= '0;
         status_ff     <= ST_OK;
         pend_ff       <= 1'b0;
      end else begin
         cfg_obj_ff    <= cfg_obj_in;
         cfg_align_ff  <= cfg_align_in;
         cfg_base_ff   <= cfg_base_in;
         geo_base_ff   <= geo_base_in;
         per_page_ff   <= per_page_in;
         active_ff     <= active_in;
         top_ff        <= top_in;
         owned_ff      <= owned_in;
         slots_ff      <= slots_in;
         live_ff       <= live_in;
         peak_ff       <= peak_in;
         slot_total_ff <= slot_total_in;
         own_cnt_ff    <= own_cnt_in;
         kind_ff       <= kind_in;
         result_ff     <= result_in;
         status_ff     <= status_in;
         pend_ff       <= pend_in;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_result_address  = result_ff;
   assign rsp_allocated_count = live_ff;
   assign rsp_frame_count     = own_cnt_ff;
   assign rsp_object_total    = slot_total_ff;
   assign rsp_peak_allocated  = peak_ff;

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_BITS'(FREE_DEPTH)) else $error("stack pointer past depth");
   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      OWN_BITS'($countones(owned_ff)) == own_cnt_ff) else $error("frame count mismatch");
   a_active_geo: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (per_page_ff != '0)) else $error("active with empty page geometry");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= live_ff) else $error("peak below live count");

endmodule

// ===== rtl/core/slab_object_allocator_top.sv =====
// Slab cache over 16 page frames of 4 KiB, with a LIFO stack of up to 8192 free
// object addresses in a single-port-write, single-port-read memory. Raise start with
// req_type and req_obj_address while busy is low; exactly one response follows,
// shown for one cycle with rsp_strobe, and it cannot be held off, so capture it
// then. An allocation from a non-empty stack passes the decide, pop and pop
// write-back states before the strobe; an accepted free passes decide and a reclaim
// check, other requests decide only. An allocation that finds the stack empty first
// fills a page, one stack write per slot, and then pops. A free that empties a page
// (when it is not the last owned page) compacts the stack one entry per cycle. Writing
// enable with 1 re-creates the cache and runs a divider for slots per page; csr_ready
// is low and busy is high meanwhile. Configuration writes are taken only while idle.
module slab_object_allocator_top
   import slab_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic [31:0]         req_obj_address,
   output logic                rsp_strobe,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_result_address,
   output logic [CNT_BITS-1:0] rsp_allocated_count,
   output logic [OWN_BITS-1:0] rsp_frame_count,
   output logic [CNT_BITS-1:0] rsp_object_total,
   output logic [CNT_BITS-1:0] rsp_peak_allocated,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   slab_cmd_type  cmd;
   slab_stat_type stat;
   logic          csr_fire;

   assign csr_fire = csr_valid && csr_ready;

   slab_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .rsp_strobe     (rsp_strobe),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_enable_bit (csr_wdata[0]),
      .stat           (stat),
      .cmd            (cmd)
   );

   slab_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_type),
      .req_obj_address     (req_obj_address),
      .csr_fire            (csr_fire),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_status          (rsp_status),
      .rsp_result_address  (rsp_result_address),
      .rsp_allocated_count (rsp_allocated_count),
      .rsp_frame_count     (rsp_frame_count),
      .rsp_object_total    (rsp_object_total),
      .rsp_peak_allocated  (rsp_peak_allocated)
   );

endmodule
